>>> src/drg_pkg.sv
package drg_pkg;

  // Width of the incoming doorbell word, the enable word and the pending word.
  localparam int WORD_BITS = 16;
  // Width of the outgoing doorbell word.
  localparam int OUT_BITS = 32;
  // Width of each configuration register.
  localparam int CFG_BITS = 5;

  localparam int CHANNELS_DEF = 16;
  localparam int PAUSE_COUNT_BITS_DEF = 8;

  localparam logic [CFG_BITS-1:0] CHANNEL_COUNT_RST = 5'd16;
  localparam logic [CFG_BITS-1:0] DOORBELL_SHIFT_RST = 5'd0;

  typedef enum logic [0:0] {
    CFG_CHANNEL_COUNT  = 1'b0,
    CFG_DOORBELL_SHIFT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_RING    = 3'd0,
    OP_OPEN    = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_PAUSE   = 3'd3,
    OP_RESUME  = 3'd4,
    OP_PARTNER = 3'd5,
    OP_SERVICE = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHANNEL = 3'd1,
    ST_OVERFLOW    = 3'd2,
    ST_NOT_PAUSED  = 3'd3,
    ST_NOTHING     = 3'd4
  } status_t;

endpackage

>>> src/doorbell_receive_gate_top.sv
// Doorbell receive gate: sixteen-channel mailbox doorbell with enable, nested pause and pending.
// A word accepted into the input register shows its result when it moves on into the result
// register, which waits while a held result is not taken; the state update happens at that same edge.
// Throughput: one word per cycle, limited only by the result register draining.
// Reset (rst_n low, synchronous): no words held, all channels closed and unpaused,
// nothing pending, channel_count = 16 and doorbell_shift = 0.
module doorbell_receive_gate_top #(
  parameter int CHANNELS = drg_pkg::CHANNELS_DEF,
  parameter int PAUSE_COUNT_BITS = drg_pkg::PAUSE_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_op,
  input  logic [3:0]                          in_channel,
  input  logic [drg_pkg::WORD_BITS-1:0]       in_incoming_bits,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_status,
  output logic [drg_pkg::OUT_BITS-1:0]        out_outgoing_doorbell,
  output logic [drg_pkg::WORD_BITS-1:0]       out_delivered,
  output logic                                out_irq_line,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [drg_pkg::CFG_BITS-1:0]        cfg_wdata
);

  import drg_pkg::*;

  // Only channels below both CHANNELS and the word width can ever be addressed,
  // so the pause counters are kept for those alone.
  localparam int USED_CH = (CHANNELS < WORD_BITS) ? CHANNELS : WORD_BITS;
  localparam int IDX_W = (USED_CH > 1) ? $clog2(USED_CH) : 1;
  localparam logic [PAUSE_COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [PAUSE_COUNT_BITS-1:0] CNT_ONE = PAUSE_COUNT_BITS'(1);

  // Configuration registers.
  logic [CFG_BITS-1:0] chan_count_r;
  logic [CFG_BITS-1:0] shift_r;

  // Input register stage.
  logic                 in_vld_r;
  op_t                  in_op_r;
  logic [3:0]           in_ch_r;
  logic [WORD_BITS-1:0] in_inc_r;

  // Channel state.
  logic [WORD_BITS-1:0]        enabled_r, enabled_nxt;
  logic [WORD_BITS-1:0]        pending_r, pending_nxt;
  logic [PAUSE_COUNT_BITS-1:0] pause_r [USED_CH];
  logic [PAUSE_COUNT_BITS-1:0] cnt_cur, cnt_nxt;
  logic                        cnt_we;

  // Result register.
  logic                 out_vld_r;
  status_t              status_r, status_nxt;
  logic [OUT_BITS-1:0]  outgoing_r, outgoing_nxt;
  logic [WORD_BITS-1:0] delivered_r, delivered_nxt;
  logic                 irq_r;

  logic                 adv;
  logic [CFG_BITS-1:0]  usable;
  logic                 bad_ch;
  logic [IDX_W-1:0]     idx;
  logic [5:0]           bit_pos;
  logic [WORD_BITS-1:0] chan_bit;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] paused;

  // The held word moves into the result register when that register is empty
  // or is being taken in this cycle.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // Usable channel count is the configured count clipped to what exists.
  assign usable = (chan_count_r > CFG_BITS'(USED_CH)) ? CFG_BITS'(USED_CH) : chan_count_r;
  assign bad_ch = (in_op_r <= OP_RESUME) && ({1'b0, in_ch_r} >= usable);
  assign idx      = in_ch_r[IDX_W-1:0];
  assign cnt_cur  = pause_r[idx];
  assign chan_bit = WORD_BITS'(1) << in_ch_r;
  assign bit_pos  = {2'b00, in_ch_r} + {1'b0, shift_r};

  // Per-channel paused and usable masks.
  for (genvar g = 0; g < WORD_BITS; g++) begin : g_mask
    assign valid_mask[g] = (CFG_BITS'(g) < usable);
    if (g < USED_CH) begin : g_cnt
      assign paused[g] = |pause_r[g];
    end else begin : g_none
      assign paused[g] = 1'b0;
    end
  end

  always_comb begin
    status_nxt    = ST_OK;
    outgoing_nxt  = '0;
    delivered_nxt = '0;
    enabled_nxt   = enabled_r;
    pending_nxt   = pending_r;
    cnt_nxt       = cnt_cur;
    cnt_we        = 1'b0;
    if (bad_ch) begin
      status_nxt = ST_BAD_CHANNEL;
    end else begin
      unique case (in_op_r)
        OP_RING: begin
          // A bit position past the top of the word rings nothing.
          outgoing_nxt = bit_pos[5] ? '0 : (OUT_BITS'(1) << bit_pos[4:0]);
        end
        OP_OPEN: begin
          enabled_nxt = enabled_r | chan_bit;
        end
        OP_CLOSE: begin
          enabled_nxt = enabled_r & ~chan_bit;
          cnt_nxt     = '0;
          cnt_we      = 1'b1;
        end
        OP_PAUSE: begin
          if (cnt_cur == CNT_MAX) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            cnt_nxt = cnt_cur + CNT_ONE;
            cnt_we  = 1'b1;
          end
        end
        OP_RESUME: begin
          if (cnt_cur == '0) begin
            status_nxt = ST_NOT_PAUSED;
          end else begin
            cnt_nxt = cnt_cur - CNT_ONE;
            cnt_we  = 1'b1;
            // The last resume drops whatever arrived while the channel was paused.
            if (cnt_cur == CNT_ONE) begin
              pending_nxt = pending_r & ~chan_bit;
            end
          end
        end
        OP_PARTNER: begin
          pending_nxt = pending_r | in_inc_r;
        end
        OP_SERVICE: begin
          if (pending_r == '0) begin
            status_nxt = ST_NOTHING;
          end else begin
            delivered_nxt = pending_r & enabled_r & ~paused & valid_mask;
            pending_nxt   = '0;
          end
        end
        default: begin
          // The unused opcode leaves everything as it is.
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= CHANNEL_COUNT_RST;
      shift_r      <= DOORBELL_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHANNEL_COUNT:  chan_count_r <= cfg_wdata;
        CFG_DOORBELL_SHIFT: shift_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_op_r  <= op_t'(in_op);
      in_ch_r  <= in_channel;
      in_inc_r <= in_incoming_bits;
    end
  end

  // Channel state commits when the word moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= '0;
      pending_r <= '0;
      for (int i = 0; i < USED_CH; i++) begin
        pause_r[i] <= '0;
      end
    end else if (adv) begin
      enabled_r <= enabled_nxt;
      pending_r <= pending_nxt;
      if (cnt_we) begin
        pause_r[idx] <= cnt_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (adv) begin
      status_r    <= status_nxt;
      outgoing_r  <= outgoing_nxt;
      delivered_r <= delivered_nxt;
      irq_r       <= (pending_nxt != '0);
    end
  end

  assign out_valid             = out_vld_r;
  assign out_status            = status_r;
  assign out_outgoing_doorbell = outgoing_r;
  assign out_delivered         = delivered_r;
  assign out_irq_line          = irq_r;

`ifndef SYNTHESIS
  // A ring never raises more than one outgoing bit.
  a_ring_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_outgoing_doorbell))
    else $error("outgoing doorbell word has more than one bit set");

  // A service that delivers something has cleared every pending bit.
  a_service_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_delivered != '0) |-> !out_irq_line && (out_status == ST_OK))
    else $error("delivery left pending bits or reported an error");

  // Only a failed-free word may carry data on the result lanes.
  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_outgoing_doorbell == '0) &&
                                           (out_delivered == '0))
    else $error("error status came with a doorbell or a delivery");

  // The irq output of a loaded result matches the committed pending word.
  a_irq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_irq_line == (pending_r != '0))
    else $error("irq line disagrees with pending state");
`endif

endmodule

>>> verif/doorbell_receive_gate_top_test.sv
`timescale 1ns / 100ps

// One expected result word, in the same layout as the result channel.
typedef struct packed {
  drg_pkg::status_t  status;
  logic [31:0]       outgoing;
  logic [15:0]       delivered;
  logic              irq;
} db_result_t;

// Doorbell predictor plus the queue of results it has promised.
class doorbell_scoreboard;
  localparam logic [drg_pkg::PAUSE_COUNT_BITS_DEF-1:0] PAUSE_MAX = '1;

  logic [4:0]  chan_count;
  logic [4:0]  bell_shift;
  logic [15:0] enabled;
  logic [15:0] pending;
  logic [drg_pkg::PAUSE_COUNT_BITS_DEF-1:0] pause_cnt [drg_pkg::CHANNELS_DEF];
  db_result_t  awaited_results [$];
  int unsigned errors;

  function new();
    chan_count = drg_pkg::CHANNEL_COUNT_RST;
    bell_shift = drg_pkg::DOORBELL_SHIFT_RST;
    enabled = '0;
    pending = '0;
    foreach (pause_cnt[i]) pause_cnt[i] = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [4:0] val);
    if (idx == drg_pkg::CFG_CHANNEL_COUNT) chan_count = val;
    else bell_shift = val;
  endfunction

  function int unsigned outstanding();
    return awaited_results.size();
  endfunction

  function void note_word(logic [2:0] op, logic [3:0] ch, logic [15:0] bits);
    db_result_t  r;
    int unsigned n;
    int unsigned pos;
    logic [15:0] usable;
    logic [15:0] paused;
    n = (chan_count > drg_pkg::WORD_BITS) ? drg_pkg::WORD_BITS : chan_count;
    usable = (n == drg_pkg::WORD_BITS) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
    r = '0;
    r.status = drg_pkg::ST_OK;
    if (op <= drg_pkg::OP_RESUME && ch >= n) begin
      r.status = drg_pkg::ST_BAD_CHANNEL;
    end else begin
      case (op)
        drg_pkg::OP_RING: begin
          pos = 32'(ch) + 32'(bell_shift);
          if (pos < 32) r.outgoing = 32'd1 << pos;
        end
        drg_pkg::OP_OPEN: enabled[ch] = 1'b1;
        drg_pkg::OP_CLOSE: begin
          enabled[ch] = 1'b0;
          pause_cnt[ch] = '0;
        end
        drg_pkg::OP_PAUSE: begin
          if (pause_cnt[ch] == PAUSE_MAX) r.status = drg_pkg::ST_OVERFLOW;
          else pause_cnt[ch] = pause_cnt[ch] + 1'b1;
        end
        drg_pkg::OP_RESUME: begin
          if (pause_cnt[ch] == '0) begin
            r.status = drg_pkg::ST_NOT_PAUSED;
          end else begin
            pause_cnt[ch] = pause_cnt[ch] - 1'b1;
            if (pause_cnt[ch] == '0) pending[ch] = 1'b0;
          end
        end
        drg_pkg::OP_PARTNER: pending = pending | bits;
        drg_pkg::OP_SERVICE: begin
          if (pending == '0) begin
            r.status = drg_pkg::ST_NOTHING;
          end else begin
            paused = '0;
            for (int i = 0; i < n; i++) paused[i] = (pause_cnt[i] != '0);
            r.delivered = pending & enabled & ~paused & usable;
            pending = '0;
          end
        end
        default: ;
      endcase
    end
    r.irq = (pending != '0);
    awaited_results.push_back(r);
  endfunction

  function void check_result(logic [2:0] status, logic [31:0] outgoing,
                             logic [15:0] delivered, logic irq);
    db_result_t e;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with no word outstanding: status %0d outgoing %h",
               $time, status, outgoing);
      errors++;
      return;
    end
    e = awaited_results.pop_front();
    if (status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      errors++;
    end
    if (outgoing !== e.outgoing) begin
      $display("%0t: outgoing_doorbell expected %h actual %h", $time, e.outgoing, outgoing);
      errors++;
    end
    if (delivered !== e.delivered) begin
      $display("%0t: delivered expected %h actual %h", $time, e.delivered, delivered);
      errors++;
    end
    if (irq !== e.irq) begin
      $display("%0t: irq_line expected %b actual %b", $time, e.irq, irq);
      errors++;
    end
  endfunction
endclass

module doorbell_receive_gate_top_test;
  import drg_pkg::*;

  // Opcode 7 is not decoded by the block; it must still answer with a plain status.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // Cycles without any handshake before the run is declared hung. The slowest
  // legal stretches are receiver stalls and sender gaps.
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [3:0]  in_channel = '0;
  logic [15:0] in_incoming_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_outgoing_doorbell;
  logic [15:0] out_delivered;
  logic        out_irq_line;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [4:0]  cfg_wdata = '0;

  doorbell_scoreboard sb = new();

  // Sender pacing and the configuration the stimulus aims its channels at.
  int unsigned burst_left = 0;
  bit          bursty = 1'b1;
  logic [4:0]  cur_count = CHANNEL_COUNT_RST;

  // Receiver pattern state.
  int unsigned ready_mode = 0;
  int unsigned mode_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  doorbell_receive_gate_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_channel            (in_channel),
    .in_incoming_bits      (in_incoming_bits),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_outgoing_doorbell (out_outgoing_doorbell),
    .out_delivered         (out_delivered),
    .out_irq_line          (out_irq_line),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // The receiver switches at random between modes: always
  // ready, mostly ready, mostly stalled, and ready with occasional long stalls.
  // Mode zero gives stretches in which results drain with no back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_mode <= 0;
      mode_cycles <= 100;
      stall_left <= 0;
    end else begin
      if (mode_cycles == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(50, 300);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  // All handshakes are observed here, at the edge, on the values that were
  // settled before it. Register writes update the predictor's copy of the
  // configuration, accepted words produce an expectation, and accepted
  // results are checked. The same block runs the hang watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_word(in_op, in_channel, in_incoming_bits);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_outgoing_doorbell, out_delivered, out_irq_line);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Presents one word and returns at the edge where it is taken. Valid stays
  // high across back-to-back words within a burst; when a burst runs out the
  // sender drops valid for a random gap, unless this stretch runs without idling.
  task automatic put_word(logic [2:0] op, logic [3:0] ch, logic [15:0] bits);
    int unsigned gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_channel <= ch;
    in_incoming_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = bursty ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Holds the sender off until every expected result has been taken. The
  // first edge lets the monitor record a word accepted at the current edge.
  // Every word yields exactly one result, so an empty queue means the block
  // is idle; a further wait covers the result register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHANNEL_COUNT) cur_count = val;
  endtask

  function automatic int unsigned usable_count();
    return (cur_count > WORD_BITS) ? WORD_BITS : cur_count;
  endfunction

  // One random word. Most channels land inside the usable range so that the
  // enable, pause and pending state gets exercised; the rest probe rejection.
  // Incoming bits are mixed between dense, single-bit and sparse patterns.
  task automatic random_word();
    int unsigned pick;
    int unsigned n;
    logic [2:0]  op;
    logic [3:0]  ch;
    logic [15:0] bits;
    pick = $urandom_range(0, 99);
    if (pick < 10) op = OP_RING;
    else if (pick < 25) op = OP_OPEN;
    else if (pick < 33) op = OP_CLOSE;
    else if (pick < 51) op = OP_PAUSE;
    else if (pick < 69) op = OP_RESUME;
    else if (pick < 83) op = OP_PARTNER;
    else if (pick < 98) op = OP_SERVICE;
    else op = OP_UNUSED;
    n = usable_count();
    if (n != 0 && $urandom_range(0, 6) != 0) ch = 4'($urandom_range(0, n - 1));
    else ch = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: bits = 16'($urandom_range(0, 16'hFFFF));
      1: bits = 16'd1 << $urandom_range(0, 15);
      2: bits = 16'($urandom_range(0, 16'hFFFF) & $urandom_range(0, 16'hFFFF));
      default: bits = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    put_word(op, ch, bits);
  endtask

  // Pushes one channel's pause counter past its ceiling so that overflow is
  // reported, checks that a paused channel is held back on service, then
  // resumes all the way down. The final resume must drop the channel's
  // pending bit, and one more resume must report that it is not paused.
  // Unrelated words are sprinkled in; they leave the chosen channel's enable and pause count alone.
  task automatic saturate_pause(logic [3:0] ch);
    logic [15:0] other;
    put_word(OP_OPEN, ch, 16'($urandom_range(0, 16'hFFFF)));
    for (int i = 0; i < 258; i++) begin
      put_word(OP_PAUSE, ch, 16'($urandom_range(0, 16'hFFFF)));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: put_word(OP_PARTNER, 4'($urandom_range(0, 15)),
                      16'($urandom_range(0, 16'hFFFF)));
          1: put_word(OP_SERVICE, 4'($urandom_range(0, 15)),
                      16'($urandom_range(0, 16'hFFFF)));
          default: put_word(OP_RING, 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 16'hFFFF)));
        endcase
      end
    end
    other = 16'($urandom_range(0, 16'hFFFF));
    put_word(OP_PARTNER, ch, other | (16'd1 << ch));
    put_word(OP_SERVICE, ch, 16'h0000);
    for (int i = 0; i < 256; i++) begin
      if (i == 254) put_word(OP_PARTNER, ch, 16'd1 << ch);
      put_word(OP_RESUME, ch, 16'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  initial begin
    logic [4:0] count_val;
    logic [4:0] shift_val;

    // Reset is held once, at the start of the run.
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset configuration, with both registers rewritten.
    write_reg(CFG_CHANNEL_COUNT, 5'd16);
    write_reg(CFG_DOORBELL_SHIFT, 5'd0);
    put_word(OP_SERVICE, 4'd0, 16'h0000);   // nothing pending yet
    put_word(OP_RESUME, 4'd0, 16'h0000);    // resume of an unpaused channel
    put_word(OP_RING, 4'd0, 16'h0000);
    put_word(OP_RING, 4'd15, 16'hFFFF);
    put_word(OP_OPEN, 4'd0, 16'h0000);
    put_word(OP_OPEN, 4'd15, 16'h0000);
    put_word(OP_OPEN, 4'd5, 16'h0000);
    put_word(OP_PARTNER, 4'd0, 16'hFFFF);
    put_word(OP_PAUSE, 4'd5, 16'h0000);
    put_word(OP_SERVICE, 4'd0, 16'h0000);   // channel 5 is paused and held back
    put_word(OP_PARTNER, 4'd9, 16'h0021);
    put_word(OP_RESUME, 4'd5, 16'h0000);    // final resume drops pending bit 5
    put_word(OP_SERVICE, 4'd0, 16'h0000);
    put_word(OP_PAUSE, 4'd15, 16'h0000);
    put_word(OP_CLOSE, 4'd15, 16'h0000);    // close also clears the pause
    put_word(OP_RESUME, 4'd15, 16'h0000);
    put_word(OP_UNUSED, 4'd15, 16'hFFFF);

    // Four channels and the largest shift: ring into bit 31, ring off the top
    // of the word, reject channel 4, and mask the stale enable of channel 5.
    write_reg(CFG_CHANNEL_COUNT, 5'd4);
    write_reg(CFG_DOORBELL_SHIFT, 5'd31);
    put_word(OP_RING, 4'd0, 16'h0000);
    put_word(OP_RING, 4'd3, 16'h0000);
    put_word(OP_RING, 4'd4, 16'h0000);
    put_word(OP_PARTNER, 4'd0, 16'h8021);
    put_word(OP_SERVICE, 4'd0, 16'h0000);

    // A count of zero rejects every channel; partner and service still work.
    write_reg(CFG_CHANNEL_COUNT, 5'd0);
    put_word(OP_OPEN, 4'd0, 16'h0000);
    put_word(OP_PARTNER, 4'd0, 16'h0001);
    put_word(OP_SERVICE, 4'd0, 16'h0000);

    // A count above sixteen is clamped.
    write_reg(CFG_CHANNEL_COUNT, 5'd31);
    write_reg(CFG_DOORBELL_SHIFT, 5'd17);
    put_word(OP_RING, 4'd15, 16'h0000);
    put_word(OP_RING, 4'd14, 16'h0000);

    // Random phases, each under its own configuration. The first two pin the
    // extremes; the rest pick from the edges and the interior. Every third
    // phase runs the sender without gaps.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        count_val = 5'd1;
        shift_val = 5'd0;
      end else if (phase == 1 || phase == 5) begin
        count_val = 5'd16;
        shift_val = 5'd16;
      end else begin
        case ($urandom_range(0, 9))
          0: count_val = 5'd1;
          1: count_val = 5'd16;
          2: count_val = 5'd0;
          3: count_val = 5'd31;
          4: count_val = 5'($urandom_range(17, 31));
          default: count_val = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 5))
          0: shift_val = 5'd0;
          1: shift_val = 5'd16;
          2: shift_val = 5'd31;
          default: shift_val = 5'($urandom_range(0, 31));
        endcase
      end
      write_reg(CFG_CHANNEL_COUNT, count_val);
      write_reg(CFG_DOORBELL_SHIFT, shift_val);
      bursty = (phase % 3 != 1);
      if (phase == 5) begin
        saturate_pause(4'($urandom_range(0, 15)));
      end else begin
        for (int i = 0; i < 100; i++) begin
          // Once, midway, the sender waits for the block to drain completely.
          if (phase == 4 && i == 50) settle();
          random_word();
        end
      end
    end

    settle();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
